// ===== rtl/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
// Used by the top level, the checker and the testbench; no dependencies.
package tcw_pkg;

    // Widths of the stream fields
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int COLOUR_W    = 4;
    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 7;
    localparam int CELL_W      = CHAR_W + ATTR_W;

    // Packed stream widths, padded to whole bytes
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 32;

    // Configuration port
    localparam int CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd1;

    // Opcodes carried in tuser
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Character codes and the blank cell (space, attribute zero)
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;

    localparam logic [COLOUR_W-1:0] FG_RESET = 4'd7;
    localparam logic [COLOUR_W-1:0] BG_RESET = 4'd0;

    // A cell holds the attribute in the high byte and the character in the low byte
    typedef logic [CELL_W-1:0] t_cell;
    localparam t_cell BLANK_CELL = {8'h00, SPACE_CODE};

endpackage

// ===== rtl/text_console_writer.sv =====
// Text console writer: takes put and read beats and gives one result beat for each; a read
// outside the screen skips the cell memory and returns a zero cell. A put that scrolls copies
// each recorded cell of a row from the row below and blanks the rest of its old text, through
// the single cell-memory port pair. A result held back by the sink stalls intake.
// Reset is synchronous, active low; configuration beats are taken in every cycle.
// After reset a clearing pass writes every cell blank, one a cycle, and zeroes the row lengths.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata fields from bit 0: char_code[7:0], read_row[4:0], read_column[6:0], zero pad
    input  logic [tcw_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // tuser fields from bit 0: opcode
    input  logic                              i_s_axis_tuser,
    // Result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata fields from bit 0: cell_char[7:0], cell_attribute[7:0], cursor_row[4:0],
    // cursor_column[6:0], newline_pending, zero pad
    output logic [tcw_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tcw_pkg::COLOUR_W-1:0]      i_cfg_data
);

    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS + 1);

    // Sequencer states
    localparam logic [3:0] S_CLR      = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_RD_ISSUE = 4'd3;
    localparam logic [3:0] S_RD_DATA  = 4'd4;
    localparam logic [3:0] S_PUT      = 4'd5;
    localparam logic [3:0] S_FINISH   = 4'd6;
    localparam logic [3:0] S_SC_START = 4'd7;
    localparam logic [3:0] S_SC_OLD   = 4'd8;
    localparam logic [3:0] S_SC_RDLEN = 4'd9;
    localparam logic [3:0] S_SC_LEN   = 4'd10;
    localparam logic [3:0] S_SC_CELL  = 4'd11;
    localparam logic [3:0] S_SC_COPY  = 4'd12;
    localparam logic [3:0] S_SC_NEXT  = 4'd13;
    localparam logic [3:0] S_SC_BOT   = 4'd14;

    logic [3:0]             r_state;
    logic [ADDR_W-1:0]      r_clr;

    // Captured input beat
    logic                   r_in_op;
    logic [CHAR_W-1:0]      r_in_char;
    logic [ROW_FIELD_W-1:0] r_in_row;
    logic [COL_FIELD_W-1:0] r_in_col;

    // Cursor and colours
    logic [ROW_W-1:0]       r_cur_row;
    logic [COL_W-1:0]       r_cur_col;
    logic [ADDR_W-1:0]      r_cur_base;
    logic                   r_pend;
    logic [COLOUR_W-1:0]    r_fg;
    logic [COLOUR_W-1:0]    r_bg;

    // Scroll walk
    logic [ROW_W-1:0]       r_sc_row;
    logic [ADDR_W-1:0]      r_sc_base;
    logic [COL_W-1:0]       r_x;
    logic [COL_W-1:0]       r_len;
    logic [COL_W-1:0]       r_old;
    logic [COL_W-1:0]       r_lim;

    // Read address of a read beat and the pending result cell
    logic [ADDR_W-1:0]      r_addr;
    t_cell                  r_res;

    // Output register
    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;

    // Memory ports
    logic                   cell_wr_en;
    logic [ADDR_W-1:0]      cell_wr_addr;
    t_cell                  cell_wr_data;
    logic                   cell_rd_en;
    logic [ADDR_W-1:0]      cell_rd_addr;
    t_cell                  cell_rd_data;
    logic                   len_wr_en;
    logic [ROW_W-1:0]       len_wr_addr;
    logic [COL_W-1:0]       len_wr_data;
    logic                   len_rd_en;
    logic [ROW_W-1:0]       len_rd_addr;
    logic [COL_W-1:0]       len_rd_data;

    // Derived values
    logic [COL_W-1:0]       cur_col_inc;
    logic [COL_W-1:0]       x_inc;
    logic [COL_W-1:0]       len_max;
    logic                   is_newline;
    logic                   read_in_range;

    assign cur_col_inc   = COL_W'(r_cur_col + 1'b1);
    assign x_inc         = COL_W'(r_x + 1'b1);
    assign len_max       = (len_rd_data > r_old) ? len_rd_data : r_old;
    assign is_newline    = (r_in_char == NEWLINE_CODE);
    assign read_in_range = (32'(r_in_row) < ROWS) && (32'(r_in_col) < COLUMNS);

    tcw_ram #(
        .DEPTH (CELLS),
        .WIDTH (CELL_W)
    ) u_cell_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cell_wr_en),
        .i_wr_addr (cell_wr_addr),
        .i_wr_data (cell_wr_data),
        .i_rd_en   (cell_rd_en),
        .i_rd_addr (cell_rd_addr),
        .o_rd_data (cell_rd_data)
    );

    tcw_ram #(
        .DEPTH (ROWS),
        .WIDTH (COL_W)
    ) u_len_ram (
        .i_clk     (i_clk),
        .i_wr_en   (len_wr_en),
        .i_wr_addr (len_wr_addr),
        .i_wr_data (len_wr_data),
        .i_rd_en   (len_rd_en),
        .i_rd_addr (len_rd_addr),
        .o_rd_data (len_rd_data)
    );

    // Memory port selection by sequencer state
    always_comb begin
        cell_wr_en   = 1'b0;
        cell_wr_addr = r_clr;
        cell_wr_data = BLANK_CELL;
        cell_rd_en   = 1'b0;
        cell_rd_addr = r_addr;
        len_wr_en    = 1'b0;
        len_wr_addr  = r_cur_row;
        len_wr_data  = r_cur_col;
        len_rd_en    = 1'b0;
        len_rd_addr  = '0;
        case (r_state)
            S_CLR: begin
                cell_wr_en  = 1'b1;
                len_wr_en   = (32'(r_clr) < ROWS);
                len_wr_addr = r_clr[ROW_W-1:0];
                len_wr_data = '0;
            end
            S_RD_ISSUE: begin
                cell_rd_en = 1'b1;
            end
            S_PUT: begin
                if (is_newline) begin
                    len_wr_en = 1'b1;
                end else begin
                    cell_wr_en   = (32'(r_cur_col) < COLUMNS);
                    cell_wr_addr = r_cur_base + ADDR_W'(r_cur_col);
                    cell_wr_data = {r_bg, r_fg, r_in_char};
                    len_wr_en    = (32'(cur_col_inc) >= COLUMNS);
                    len_wr_data  = cur_col_inc;
                end
            end
            S_SC_START: begin
                len_rd_en = 1'b1;
            end
            S_SC_RDLEN: begin
                len_rd_en   = 1'b1;
                len_rd_addr = ROW_W'(r_sc_row + 1'b1);
            end
            S_SC_LEN: begin
                len_wr_en   = 1'b1;
                len_wr_addr = r_sc_row;
                len_wr_data = len_rd_data;
            end
            S_SC_CELL: begin
                if (r_x < r_len) begin
                    cell_rd_en   = 1'b1;
                    cell_rd_addr = r_sc_base + ADDR_W'(COLUMNS) + ADDR_W'(r_x);
                end else begin
                    cell_wr_en   = 1'b1;
                    cell_wr_addr = r_sc_base + ADDR_W'(r_x);
                end
            end
            S_SC_COPY: begin
                cell_wr_en   = 1'b1;
                cell_wr_addr = r_sc_base + ADDR_W'(r_x);
                cell_wr_data = cell_rd_data;
            end
            S_SC_BOT: begin
                if (r_x < r_old) begin
                    cell_wr_en   = 1'b1;
                    cell_wr_addr = r_sc_base + ADDR_W'(r_x);
                end else begin
                    len_wr_en   = 1'b1;
                    len_wr_addr = ROW_W'(ROWS - 1);
                    len_wr_data = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Colour registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_FOREGROUND) begin
                r_fg <= i_cfg_data;
            end else if (i_cfg_index == CFG_BACKGROUND) begin
                r_bg <= i_cfg_data;
            end
        end
    end

    // Input capture; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_axis_tvalid) begin
            r_in_op   <= i_s_axis_tuser;
            r_in_char <= i_s_axis_tdata[7:0];
            r_in_row  <= i_s_axis_tdata[12:8];
            r_in_col  <= i_s_axis_tdata[19:13];
        end
    end

    // Main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr      <= '0;
            r_cur_row  <= '0;
            r_cur_col  <= '0;
            r_cur_base <= '0;
            r_pend     <= 1'b0;
            r_sc_row   <= '0;
            r_sc_base  <= '0;
            r_x        <= '0;
            r_len      <= '0;
            r_old      <= '0;
            r_lim      <= '0;
            r_addr     <= '0;
            r_res      <= '0;
        end else begin
            case (r_state)
                S_CLR: begin
                    if (r_clr == ADDR_W'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= ADDR_W'(r_clr + 1'b1);
                    end
                end
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_res <= '0;
                    if (r_in_op == OP_READ) begin
                        r_addr  <= ADDR_W'(r_in_row * COLUMNS) + ADDR_W'(r_in_col);
                        r_state <= read_in_range ? S_RD_ISSUE : S_FINISH;
                    end else if (!r_pend) begin
                        r_state <= S_PUT;
                    end else if (r_cur_row != ROW_W'(ROWS - 1)) begin
                        // Pending advance to the next row without a scroll
                        r_cur_row  <= ROW_W'(r_cur_row + 1'b1);
                        r_cur_base <= r_cur_base + ADDR_W'(COLUMNS);
                        r_cur_col  <= '0;
                        r_pend     <= 1'b0;
                        r_state    <= S_PUT;
                    end else begin
                        r_sc_row  <= '0;
                        r_sc_base <= '0;
                        r_state   <= S_SC_START;
                    end
                end
                S_RD_ISSUE: begin
                    r_state <= S_RD_DATA;
                end
                S_RD_DATA: begin
                    r_res   <= cell_rd_data;
                    r_state <= S_FINISH;
                end
                S_PUT: begin
                    if (is_newline) begin
                        r_pend <= 1'b1;
                    end else begin
                        r_cur_col <= cur_col_inc;
                        if (32'(cur_col_inc) >= COLUMNS) begin
                            r_pend <= 1'b1;
                        end
                    end
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                // Scroll: length of row zero becomes the first old length
                S_SC_START: begin
                    r_state <= S_SC_OLD;
                end
                S_SC_OLD: begin
                    r_old   <= len_rd_data;
                    r_state <= S_SC_RDLEN;
                end
                S_SC_RDLEN: begin
                    r_state <= S_SC_LEN;
                end
                S_SC_LEN: begin
                    r_len <= len_rd_data;
                    r_lim <= len_max;
                    r_x   <= '0;
                    r_state <= (len_max == '0) ? S_SC_NEXT : S_SC_CELL;
                end
                S_SC_CELL: begin
                    if (r_x < r_len) begin
                        r_state <= S_SC_COPY;
                    end else if (x_inc == r_lim) begin
                        r_state <= S_SC_NEXT;
                    end else begin
                        r_x <= x_inc;
                    end
                end
                S_SC_COPY: begin
                    if (x_inc == r_lim) begin
                        r_state <= S_SC_NEXT;
                    end else begin
                        r_x     <= x_inc;
                        r_state <= S_SC_CELL;
                    end
                end
                S_SC_NEXT: begin
                    // The new length of this row is the old length of the next one
                    r_old     <= r_len;
                    r_sc_row  <= ROW_W'(r_sc_row + 1'b1);
                    r_sc_base <= r_sc_base + ADDR_W'(COLUMNS);
                    r_x       <= '0;
                    if (r_sc_row == ROW_W'(ROWS - 2)) begin
                        r_state <= S_SC_BOT;
                    end else begin
                        r_state <= S_SC_RDLEN;
                    end
                end
                S_SC_BOT: begin
                    if (r_x < r_old) begin
                        r_x <= x_inc;
                    end else begin
                        r_cur_col <= '0;
                        r_pend    <= 1'b0;
                        r_state   <= S_PUT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FINISH && (!r_out_valid || i_m_axis_tready)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH && (!r_out_valid || i_m_axis_tready)) begin
            r_out_data <= {3'b000, r_pend, COL_FIELD_W'(r_cur_col),
                           ROW_FIELD_W'(r_cur_row), r_res};
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

    // A full line always leaves a newline pending
    a_full_line_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cur_col) == COLUMNS) |-> r_pend)
        else $error("cursor at line end without pending newline");

    // The cursor base address tracks the cursor row
    a_cursor_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLR) |-> (32'(r_cur_base) == 32'(r_cur_row) * COLUMNS))
        else $error("cursor base address out of step with cursor row");

    // An accepted beat is dispatched in the next cycle
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (r_state == S_DISPATCH))
        else $error("accepted beat not dispatched");

    // A scroll copy only touches columns inside the source row length
    a_copy_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SC_COPY) |-> (r_x < r_len))
        else $error("scroll copy beyond source row length");

endmodule

// ===== rtl/tcw_ram.sv =====
// Simple dual-port memory: one write port and one registered read port.
// Used for the cell store and for the row-length table; no dependencies.
module tcw_ram #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== verif/text_console_writer_checker.sv =====
// Checker for the text console writer: watches the input, result and configuration channels,
// keeps its own copy of the screen, cursor and colours, and compares every result beat.
// Depends on tcw_pkg for field widths, opcodes, register indexes and the blank cell.
`timescale 1ns / 100ps

module text_console_writer_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    input  logic                            i_s_axis_tready,
    input  logic [tcw_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    input  logic                            i_s_axis_tuser,
    input  logic                            i_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    input  logic [tcw_pkg::OUT_DATA_W-1:0]  i_m_axis_tdata,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tcw_pkg::COLOUR_W-1:0]    i_cfg_data,
    output int                              o_fail_count,
    output int                              o_outstanding
);

    import tcw_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0]      cell_char;
        logic [ATTR_W-1:0]      cell_attr;
        logic [ROW_FIELD_W-1:0] row;
        logic [COL_FIELD_W-1:0] col;
        logic                   nl;
    } t_reply;

    // Shadow copy of the console state.
    t_cell               screen [ROWS*COLUMNS];
    int                  line_len [ROWS];
    int                  cur_row;
    int                  cur_col;
    logic                nl_flag;
    logic [COLOUR_W-1:0] fg;
    logic [COLOUR_W-1:0] bg;

    t_reply pending_replies [$];
    int     fail_count = 0;

    task automatic clear_screen();
        for (int i = 0; i < ROWS*COLUMNS; i++) screen[i] = BLANK_CELL;
        for (int r = 0; r < ROWS; r++) line_len[r] = 0;
        cur_row = 0;
        cur_col = 0;
        nl_flag = 1'b0;
        fg      = FG_RESET;
        bg      = BG_RESET;
    endtask

    // Each row takes the recorded part of the row below; the rest of its old text is blanked.
    task automatic scroll_screen_up();
        int keep;
        int old;
        for (int r = 0; r < ROWS - 1; r++) begin
            keep = (line_len[r+1] > COLUMNS) ? COLUMNS : line_len[r+1];
            old  = (line_len[r] > COLUMNS) ? COLUMNS : line_len[r];
            for (int x = 0; x < keep; x++) screen[r*COLUMNS + x] = screen[(r+1)*COLUMNS + x];
            for (int x = keep; x < old; x++) screen[r*COLUMNS + x] = BLANK_CELL;
            line_len[r] = keep;
        end
        keep = (line_len[ROWS-1] > COLUMNS) ? COLUMNS : line_len[ROWS-1];
        for (int x = 0; x < keep; x++) screen[(ROWS-1)*COLUMNS + x] = BLANK_CELL;
        line_len[ROWS-1] = 0;
    endtask

    task automatic next_line();
        cur_row++;
        if (cur_row > ROWS - 1) begin
            scroll_screen_up();
            cur_row = ROWS - 1;
        end
        cur_col = 0;
        nl_flag = 1'b0;
    endtask

    // Applies one accepted input beat to the shadow state and forms the result it should give.
    task automatic predict_reply(input logic op, input logic [IN_DATA_W-1:0] data,
                                 output t_reply reply);
        logic [CHAR_W-1:0] ch;
        int                rd_row;
        int                rd_col;
        ch     = data[7:0];
        rd_row = data[12:8];
        rd_col = data[19:13];
        reply  = '0;
        if (op == OP_READ) begin
            if (rd_row < ROWS && rd_col < COLUMNS) begin
                reply.cell_char = screen[rd_row*COLUMNS + rd_col][CHAR_W-1:0];
                reply.cell_attr = screen[rd_row*COLUMNS + rd_col][CELL_W-1:CHAR_W];
            end
        end else begin
            if (nl_flag) next_line();
            if (ch == NEWLINE_CODE) begin
                nl_flag           = 1'b1;
                line_len[cur_row] = cur_col;
            end else begin
                if (cur_col < COLUMNS) screen[cur_row*COLUMNS + cur_col] = {bg, fg, ch};
                cur_col++;
                if (cur_col > COLUMNS - 1) begin
                    nl_flag           = 1'b1;
                    line_len[cur_row] = cur_col;
                end
            end
        end
        reply.row = cur_row[ROW_FIELD_W-1:0];
        reply.col = cur_col[COL_FIELD_W-1:0];
        reply.nl  = nl_flag;
    endtask

    // Results are checked before new input beats are predicted, so a result can never be
    // matched against an item accepted at the same edge.
    always @(posedge i_clk) begin : monitor
        t_reply want;
        t_reply got;
        if (!i_rst_n) begin
            clear_screen();
            pending_replies.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FOREGROUND: fg = i_cfg_data;
                    CFG_BACKGROUND: bg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.cell_char = i_m_axis_tdata[7:0];
                got.cell_attr = i_m_axis_tdata[15:8];
                got.row       = i_m_axis_tdata[20:16];
                got.col       = i_m_axis_tdata[27:21];
                got.nl        = i_m_axis_tdata[28];
                if (pending_replies.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result beat with none expected: data %h",
                                 $realtime, i_m_axis_tdata);
                end else begin
                    want = pending_replies.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: result mismatch: expected char %h attr %h row %0d col %0d nl %0d",
                                     $realtime, want.cell_char, want.cell_attr, want.row,
                                     want.col, want.nl);
                            $display("%0t: result mismatch: actual char %h attr %h row %0d col %0d nl %0d",
                                     $realtime, got.cell_char, got.cell_attr, got.row,
                                     got.col, got.nl);
                        end
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predict_reply(i_s_axis_tuser, i_s_axis_tdata, want);
                pending_replies.push_back(want);
            end
        end
        o_fail_count  <= fail_count;
        o_outstanding <= pending_replies.size();
    end

endmodule

// ===== verif/text_console_writer_tb.sv =====
// Testbench top for the text console writer: clock, reset, stimulus on the input and
// configuration channels, result-side flow control, and the verdict.
// Depends on tcw_pkg, the text_console_writer RTL and text_console_writer_checker.
`timescale 1ns / 100ps

module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int COLUMNS       = 80;
    localparam int ROWS          = 25;
    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 20;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   s_tvalid        = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata         = '0;
    logic                   s_tuser         = OP_PUT;
    logic                   m_tvalid;
    logic                   m_tready        = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_valid       = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index       = CFG_FOREGROUND;
    logic [COLOUR_W-1:0]    cfg_data        = '0;

    int fail_count;
    int outstanding;
    int cycle_count    = 0;
    int beats_sent     = 0;
    int src_idle_pct   = 0;
    int sink_idle_pct  = 0;
    int stall_requests = 0;
    int stall_served   = 0;
    int stall_left     = 0;

    always #5 i_clk = ~i_clk;

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    text_console_writer_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) console_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    // Hard limit on the run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("** text_console_writer: FAILED **");
            $finish;
        end
    end

    // Result-side flow control: random stalls, plus a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (stall_requests != stall_served) begin
            stall_served = stall_requests;
            stall_left   = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready = 1'b0;
        end else begin
            m_tready = ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Offers one input beat, starting and ending at a falling edge; tvalid stays high on return.
    task automatic send_beat(input logic op, input logic [7:0] ch, input logic [4:0] row,
                             input logic [6:0] col);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {4'b0000, col, row, ch};
        do @(posedge i_clk); while (!s_tready);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic put_char(input logic [7:0] ch);
        send_beat(OP_PUT, ch, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
    endtask

    task automatic read_cell(input logic [4:0] row, input logic [6:0] col);
        send_beat(OP_READ, 8'($urandom_range(0, 255)), row, col);
    endtask

    // Read mostly inside the screen, now and then anywhere the fields reach.
    task automatic read_random_cell();
        if ($urandom_range(0, 9) == 0)
            read_cell(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
        else
            read_cell(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLUMNS - 1)));
    endtask

    task automatic put_glyph();
        logic [7:0] ch;
        ch = 8'($urandom_range(0, 255));
        if (ch == NEWLINE_CODE) ch = ch + 8'd1;
        put_char(ch);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOUR_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // Stops offering input and waits until every expected result has been taken.
    task automatic drain();
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    // Mostly text lines of random content ended by newlines, mixed with reads, blank lines
    // that drive scrolling, full lines, and some raw bytes.
    task automatic run_random(input int count);
        int target;
        int kind;
        int len;
        target = beats_sent + count;
        while (beats_sent < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12)
                                                 : $urandom_range(COLUMNS - 4, COLUMNS + 4);
                for (int i = 0; i < len; i++) begin
                    put_glyph();
                    if ($urandom_range(0, 99) < 12) read_random_cell();
                end
                if (len < COLUMNS || $urandom_range(0, 1) == 1) put_char(NEWLINE_CODE);
            end else if (kind < 75) begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) read_random_cell();
            end else if (kind < 88) begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++) put_char(NEWLINE_CODE);
            end else begin
                put_char(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: blank screen, reads at and beyond the edges, extreme bytes,
        // newline after newline, and both colour extremes.
        read_cell(5'd0, 7'd0);
        read_cell(5'(ROWS - 1), 7'(COLUMNS - 1));
        read_cell(5'(ROWS), 7'd0);
        read_cell(5'd31, 7'd127);
        read_cell(5'd0, 7'(COLUMNS));
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h41);
        put_char(NEWLINE_CODE);
        put_char(NEWLINE_CODE);
        put_char(8'h42);
        read_cell(5'd0, 7'd0);
        read_cell(5'd0, 7'd1);
        read_cell(5'd2, 7'd0);
        drain();
        write_reg(CFG_FOREGROUND, 4'hF);
        write_reg(CFG_BACKGROUND, 4'hF);
        put_char(8'h43);
        read_cell(5'd2, 7'd1);
        drain();
        write_reg(CFG_FOREGROUND, 4'h0);
        write_reg(CFG_BACKGROUND, 4'h0);
        write_reg(2'd2, 4'hF);
        write_reg(2'd3, 4'hA);
        put_char(8'h44);
        read_cell(5'd2, 7'd2);
        read_cell(5'd2, 7'd1);
        drain();

        // Sender idles less than the receiver, with one long receiver hold-off.
        write_reg(CFG_FOREGROUND, 4'($urandom_range(0, 15)));
        write_reg(CFG_BACKGROUND, 4'($urandom_range(0, 15)));
        src_idle_pct  = 26;
        sink_idle_pct = 52;
        run_random(100);
        stall_requests++;
        run_random(200);
        drain();

        // Receiver idles less than the sender.
        write_reg(CFG_FOREGROUND, 4'($urandom_range(0, 15)));
        write_reg(CFG_BACKGROUND, 4'($urandom_range(0, 15)));
        src_idle_pct  = 52;
        sink_idle_pct = 26;
        run_random(300);
        drain();

        // Neither side idles.
        write_reg(CFG_FOREGROUND, FG_RESET);
        write_reg(CFG_BACKGROUND, 4'hF);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random(300);
        drain();

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("** text_console_writer: PASSED **");
        end else begin
            $display("** text_console_writer: FAILED **");
        end
        $finish;
    end

endmodule
